/* hw/rtl/rpn_pkg.sv */
// Package for the RPN stack calculator: stack geometry, operation codes,
// divider request and response structs for the datapath. No dependencies.
package rpn_pkg;

    localparam int StackDepth = 128;
    localparam int AddrW = $clog2(StackDepth);
    localparam int PtrW = $clog2(StackDepth + 1);
    localparam int DepthW = 8;
    localparam int ValW = 32;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_PRINT = 3'd5
    } op_t;

    typedef struct packed {
        logic start;
        logic signed [ValW-1:0] num;
        logic signed [ValW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic signed [ValW-1:0] quo;
    } div_rsp_t;

endpackage

/* hw/rtl/rpn_divider.sv */
// Iterative signed Q16.16 divider: (num * 65536) / den, truncated toward
// zero and saturated, one quotient bit per cycle. Depends on rpn_pkg.
module rpn_divider
    import rpn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int NumW = 48;
    localparam int CntW = $clog2(NumW + 1);

    logic            busy_reg, busy_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [NumW-1:0] quo_reg, quo_next;
    logic [32:0]     rem_reg, rem_next;
    logic [31:0]     den_reg, den_next;
    logic            neg_reg, neg_next;
    logic            done_reg, done_next;
    logic [33:0]     trial;
    logic [NumW:0]   sq;
    logic signed [NumW:0] sres;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[NumW-1]} - {2'b00, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = CntW'(NumW);
            quo_next = {(req.num[31] ? 32'(-req.num) : 32'(req.num)), 16'd0};
            rem_next = '0;
            den_next = req.den[31] ? 32'(-req.den) : 32'(req.den);
            neg_next = req.num[31] ^ req.den[31];
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[NumW-1]};
                quo_next = {quo_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        sq = {1'b0, quo_reg};
        sres = neg_reg ? -$signed(sq) : $signed(sq);
        rsp.done = done_reg;
        if (sres > $signed({{17{1'b0}}, 32'h7FFFFFFF}))
            rsp.quo = 32'sh7FFFFFFF;
        else if (sres < $signed({{17{1'b1}}, 32'h80000000}))
            rsp.quo = 32'sh80000000;
        else
            rsp.quo = sres[31:0];
    end

endmodule

/* hw/rtl/rpn_stack_calculator.sv */
// Push and unknown codes go from IDLE straight to OUT; print and a divide by zero
// pass RD_R, add and subtract RD_R and RD_L, multiply RD_R, RD_L and MUL, and
// divide RD_R, RD_L and DIV, where it waits for the divider; OUT holds until ready;
// the stack is a 128-entry memory with one port and a registered read.
// Top level of the RPN calculator. Depends on rpn_pkg and rpn_divider.
module rpn_stack_calculator
    import rpn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // operation[2:0], operand_value[34:3], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // printed_value[31:0], printed[32], underflow[33],
                                       // overflow[34], zero_divide[35], unknown_op[36],
                                       // depth[44:37], zero fill
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD_R = 7'b0000010,
        S_RD_L = 7'b0000100,
        S_CALC = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [ValW-1:0] mem [StackDepth];
    logic [ValW-1:0] rd_data;
    logic            mem_we;
    logic [AddrW-1:0] mem_addr;
    logic [ValW-1:0] mem_wd;

    logic [PtrW-1:0] sp_reg, sp_next;
    logic [2:0]      op_reg, op_next;
    logic [ValW-1:0] r_reg, r_next;
    logic [ValW-1:0] pv_reg, pv_next;
    logic            prn_reg, prn_next, und_reg, und_next, ovf_reg, ovf_next;
    logic            zd_reg, zd_next, unk_reg, unk_next;
    logic            rv_pending_reg, rv_pending_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [ValW-1:0] lval;
    logic            l_ok_reg, l_ok_next;
    div_req_t        dreq;
    div_rsp_t        drsp;
    logic signed [47:0] mq;

    rpn_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        rd_data <= mem[mem_addr];
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {3'b000, DepthW'(sp_reg), unk_reg, zd_reg, ovf_reg, und_reg,
                           prn_reg, pv_reg};
    assign lval = l_ok_reg ? rd_data : '0;
    assign mq = prod_reg[63:16];

    always_comb
    begin
        state_next = state_reg;
        sp_next = sp_reg;
        op_next = op_reg;
        r_next = r_reg;
        pv_next = pv_reg;
        prn_next = prn_reg;
        und_next = und_reg;
        ovf_next = ovf_reg;
        zd_next = zd_reg;
        unk_next = unk_reg;
        rv_pending_next = rv_pending_reg;
        l_ok_next = l_ok_reg;
        prod_next = prod_reg;
        mem_we = 1'b0;
        mem_addr = AddrW'(sp_reg - 1'b1);
        mem_wd = '0;
        dreq.start = 1'b0;
        dreq.num = $signed(lval);
        dreq.den = $signed(r_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next = s_axis_tdata[2:0];
                    pv_next = '0;
                    prn_next = 1'b0;
                    und_next = 1'b0;
                    ovf_next = 1'b0;
                    zd_next = 1'b0;
                    unk_next = 1'b0;
                    rv_pending_next = (sp_reg != '0);
                    priority if (s_axis_tdata[2:0] == OP_PUSH)
                    begin
                        if (sp_reg < PtrW'(StackDepth))
                        begin
                            mem_we = 1'b1;
                            mem_addr = AddrW'(sp_reg);
                            mem_wd = s_axis_tdata[34:3];
                            sp_next = sp_reg + 1'b1;
                        end
                        else
                            ovf_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (s_axis_tdata[2:0] > OP_PRINT)
                    begin
                        unk_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        if (sp_reg == '0)
                            und_next = 1'b1;
                        else
                            sp_next = sp_reg - 1'b1;
                        state_next = S_RD_R;
                    end
                end
            end
            S_RD_R:
            begin
                r_next = rv_pending_reg ? rd_data : '0;
                if (op_reg == OP_PRINT)
                begin
                    pv_next = rv_pending_reg ? rd_data : '0;
                    prn_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (op_reg == OP_DIV && (!rv_pending_reg || rd_data == '0))
                begin
                    zd_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    l_ok_next = (sp_reg != '0);
                    if (sp_reg == '0)
                        und_next = 1'b1;
                    else
                        sp_next = sp_reg - 1'b1;
                    state_next = S_RD_L;
                end
            end
            S_RD_L:
            begin
                state_next = S_CALC;
                if (op_reg == OP_MUL)
                begin
                    prod_next = $signed(lval) * $signed(r_reg);
                    state_next = S_MUL;
                end
                else if (op_reg == OP_DIV)
                begin
                    dreq.start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_addr = AddrW'(sp_reg);
                    mem_wd = (op_reg == OP_ADD) ? lval + r_reg : lval - r_reg;
                    sp_next = sp_reg + 1'b1;
                    state_next = S_OUT;
                end
            end
            S_MUL:
            begin
                mem_we = 1'b1;
                mem_addr = AddrW'(sp_reg);
                if (mq > 48'sh7FFFFFFF)
                    mem_wd = 32'h7FFFFFFF;
                else if (mq < -48'sh80000000)
                    mem_wd = 32'h80000000;
                else
                    mem_wd = mq[31:0];
                sp_next = sp_reg + 1'b1;
                state_next = S_OUT;
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    mem_we = 1'b1;
                    mem_addr = AddrW'(sp_reg);
                    mem_wd = drsp.quo;
                    sp_next = sp_reg + 1'b1;
                    state_next = S_OUT;
                end
            end
            S_CALC:
                state_next = S_OUT;
            S_OUT:
            begin
                if (m_axis_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        r_reg <= r_next;
        pv_reg <= pv_next;
        prn_reg <= prn_next;
        und_reg <= und_next;
        ovf_reg <= ovf_next;
        zd_reg <= zd_next;
        unk_reg <= unk_next;
        rv_pending_reg <= rv_pending_next;
        l_ok_reg <= l_ok_next;
        prod_reg <= prod_next;
    end

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PtrW'(StackDepth)) else $error("stack pointer beyond depth");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == S_DIV) else $error("divider result unexpected");
    a_sp_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> $stable(sp_reg)) else $error("pointer moved at output");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the RPN stack calculator over Q16.16 values.
// Tokens drive a local stack predictor; each result word is checked as a whole.
module testbench
    import rpn_pkg::*;
();

    typedef struct packed {
        logic [2:0]  fill;
        logic [7:0]  depth;
        logic        unknown_op;
        logic        zero_divide;
        logic        overflow;
        logic        underflow;
        logic        printed;
        logic [31:0] shown;
    } calc_result_t;

    localparam logic [2:0] OP_UNKNOWN_A = 3'd6;
    localparam logic [2:0] OP_UNKNOWN_B = 3'd7;
    localparam int IdleLimit = 20000;
    localparam int SinkHoldCycles = 200;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    logic [31:0]  model_stack [StackDepth];
    int           model_depth;
    calc_result_t pending_results [$];
    int           mismatch_count;
    int           result_count;
    int           token_count;
    int           idle_cycles = 0;
    int           sink_hold = 0;
    int           hold_requests;
    int           holds_served = 0;
    bit           sink_steady;
    bit           send_steady;

    rpn_stack_calculator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] take_top(inout bit under);
        if (model_depth > 0) begin
            model_depth--;
            return model_stack[model_depth];
        end
        under = 1'b1;
        return 32'd0;
    endfunction

    function automatic void put_top(logic [31:0] v, inout bit over);
        if (model_depth < StackDepth) begin
            model_stack[model_depth] = v;
            model_depth++;
        end else begin
            over = 1'b1;
        end
    endfunction

    function automatic calc_result_t evaluate_token(logic [2:0] op, logic [31:0] operand);
        calc_result_t     res;
        bit               under;
        bit               over;
        logic [31:0]      rhs;
        logic [31:0]      lhs;
        logic signed [63:0] wide;
        res = '0;
        under = 1'b0;
        over = 1'b0;
        case (op)
            OP_PUSH: put_top(operand, over);
            OP_ADD, OP_SUB, OP_MUL:
            begin
                rhs = take_top(under);
                lhs = take_top(under);
                if (op == OP_ADD) begin
                    put_top(lhs + rhs, over);
                end else if (op == OP_SUB) begin
                    put_top(lhs - rhs, over);
                end else begin
                    wide = $signed({{32{lhs[31]}}, lhs}) * $signed({{32{rhs[31]}}, rhs});
                    put_top(clamp32(wide >>> 16), over);
                end
            end
            OP_DIV:
            begin
                rhs = take_top(under);
                if (rhs == 32'd0) begin
                    res.zero_divide = 1'b1;
                end else begin
                    lhs = take_top(under);
                    wide = ($signed({{32{lhs[31]}}, lhs}) <<< 16)
                        / $signed({{32{rhs[31]}}, rhs});
                    put_top(clamp32(wide), over);
                end
            end
            OP_PRINT:
            begin
                res.shown = take_top(under);
                res.printed = 1'b1;
            end
            default: res.unknown_op = 1'b1;
        endcase
        res.underflow = under;
        res.overflow = over;
        res.depth = model_depth[7:0];
        return res;
    endfunction

    function automatic bit roll_idle();
        return $urandom_range(99) < 24;
    endfunction

    task automatic send_token(logic [2:0] op, logic [31:0] operand);
        while (!send_steady && roll_idle()) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, operand, op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_results.push_back(evaluate_token(op, operand));
        token_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    task automatic test_directed_corners();
        send_token(OP_PRINT, 32'd0);
        send_token(OP_ADD, 32'd0);
        send_token(OP_DIV, 32'd0);
        send_token(OP_UNKNOWN_A, 32'hFFFF_FFFF);
        send_token(OP_UNKNOWN_B, 32'h1234_5678);
        send_token(OP_PUSH, 32'h7FFF_FFFF);
        send_token(OP_PUSH, 32'h7FFF_FFFF);
        send_token(OP_MUL, 32'd0);
        send_token(OP_PUSH, 32'h8000_0000);
        send_token(OP_MUL, 32'd0);
        send_token(OP_PUSH, 32'h8000_0000);
        send_token(OP_PUSH, 32'h0000_8000);
        send_token(OP_DIV, 32'd0);
        send_token(OP_PUSH, 32'hFFFF_FFFF);
        send_token(OP_PUSH, 32'h0001_0000);
        send_token(OP_MUL, 32'd0);
        send_token(OP_PUSH, 32'h7FFF_FFFF);
        send_token(OP_PUSH, 32'd1);
        send_token(OP_ADD, 32'd0);
        send_token(OP_PUSH, 32'd0);
        send_token(OP_DIV, 32'd0);
        send_token(OP_PUSH, 32'h0003_0000);
        send_token(OP_SUB, 32'd0);
        send_token(OP_PRINT, 32'd0);
        send_token(OP_PRINT, 32'd0);
        wait_drained();
    endtask

    task automatic test_stack_full();
        repeat (StackDepth + 4) send_token(OP_PUSH, $urandom());
        repeat (StackDepth + 2) send_token(OP_PRINT, $urandom());
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_requests++;
        repeat (40) send_token(OP_PUSH, $urandom());
        repeat (40) send_token(OP_DIV, $urandom());
        wait_drained();
    endtask

    task automatic test_random_tokens(int count);
        logic [31:0] val;
        int          pick;
        for (int i = 0; i < count; i++) begin
            send_steady = (i >= count / 3) && (i < count / 2);
            pick = $urandom_range(99);
            case ($urandom_range(3))
                0: val = $urandom();
                1: val = $urandom_range(32'h0004_0000) - 32'h0002_0000;
                2: val = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
                default: val = $urandom_range(4) * 32'h0001_0000;
            endcase
            if (pick < 40 && model_depth < StackDepth) begin
                send_token(OP_PUSH, val);
            end else if (pick < 85) begin
                send_token(3'($urandom_range(OP_ADD, OP_DIV)), val);
            end else if (pick < 95) begin
                send_token(OP_PRINT, val);
            end else begin
                send_token(3'($urandom_range(7)), val);
            end
        end
        send_steady = 1'b0;
        wait_drained();
    endtask

    always @(negedge clk) begin
        if (hold_requests != holds_served) begin
            m_axis_tready <= 1'b0;
            sink_hold <= SinkHoldCycles - 1;
            holds_served <= hold_requests;
        end else if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_axis_tready <= sink_steady || !roll_idle();
        end
    end

    always @(posedge clk) begin
        calc_result_t got;
        calc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("Unexpected result word %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch at result %0d:", result_count);
                        $display("  expected value=%h prt=%b un=%b ov=%b zd=%b uk=%b depth=%0d",
                            want.shown, want.printed, want.underflow, want.overflow,
                            want.zero_divide, want.unknown_op, want.depth);
                        $display("  actual   value=%h prt=%b un=%b ov=%b zd=%b uk=%b depth=%0d",
                            got.shown, got.printed, got.underflow, got.overflow,
                            got.zero_divide, got.unknown_op, got.depth);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        model_depth = 0;
        mismatch_count = 0;
        result_count = 0;
        token_count = 0;
        hold_requests = 0;
        sink_steady = 1'b0;
        send_steady = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_corners();
        test_stack_full();
        test_backpressure();
        test_random_tokens(400);
        sink_steady = 1'b1;
        test_random_tokens(200);
        sink_steady = 1'b0;
        test_random_tokens(400);
        repeat (60) @(negedge clk);
        $display("Sent %0d tokens and checked %0d result words, covering empty and full stack,",
            token_count, result_count);
        $display("division by zero, saturation, unknown codes and long output stalls.");
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("rpn_stack_calculator test passed");
        end else begin
            $display("rpn_stack_calculator test failed");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= IdleLimit);
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("rpn_stack_calculator test failed");
        $finish;
    end

endmodule
